@@ rtl/paged_translation_lru_frames_defines.svh @@
// Assertion macros for the paged translation block.
// Included by the top level; expects clk and rst_n in scope.
`ifndef PAGED_TRANSLATION_LRU_FRAMES_DEFINES_SVH
`define PAGED_TRANSLATION_LRU_FRAMES_DEFINES_SVH

// Same-cycle implication, muted during reset.
`define PTL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, muted during reset.
`define PTL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/ptl_pkg.sv @@
// Shared constants, codes and control structs of the paged translation block.
// No dependencies; imported by every module of the block.
`default_nettype none

package ptl_pkg;

    localparam int NUM_PROCS       = 4;
    localparam int PAGES_PER_TABLE = 16;
    localparam int FRAME_COUNT     = 8;
    localparam int LINES_PER_PAGE  = 3;
    localparam int STAMP_BITS      = 32;

    localparam int CMD_W    = 2;
    localparam int PID_W    = 2;
    localparam int LINE_W   = 8;
    localparam int STATUS_W = 3;
    localparam int FRAME_W  = 3;
    localparam int ADDR_W   = 5;

    localparam int ENTRY_COUNT = NUM_PROCS * PAGES_PER_TABLE;
    localparam int IDX_W       = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
    localparam int REM_W       = (LINES_PER_PAGE > 1) ? $clog2(LINES_PER_PAGE) : 1;

    // reciprocal of the page length, exact for every LINE_W-bit line
    localparam int DIV_SHIFT  = LINE_W + REM_W;
    localparam int DIV_RECIP  = ((2 ** DIV_SHIFT) + LINES_PER_PAGE - 1) / LINES_PER_PAGE;
    localparam int DIV_PROD_W = LINE_W + DIV_SHIFT + 1;

    typedef enum logic [CMD_W-1:0] {
        CMD_ACCESS = 2'd0,
        CMD_FAULT  = 2'd1,
        CMD_CREATE = 2'd2,
        CMD_FREE   = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_FAULT    = 3'd1,
        ST_LOADED   = 3'd2,
        ST_EVICTED  = 3'd3,
        ST_NO_TABLE = 3'd4,
        ST_RANGE    = 3'd5,
        ST_EXISTS   = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_DECODE,
        S_LOOKUP,
        S_SCAN,
        S_COMMIT,
        S_FINISH
    } state_t;

    // page table requests
    typedef struct packed {
        logic               rd_en;
        logic [IDX_W-1:0]   rd_idx;
        logic               wr_en;
        logic [IDX_W-1:0]   wr_idx;
        logic [FRAME_W-1:0] wr_frame;
        logic               clr_en;
        logic [PID_W-1:0]   clr_pid;
        logic               inv_en;
        logic [IDX_W-1:0]   inv_idx;
    } pt_ctrl_t;

    // frame bookkeeping requests
    typedef struct packed {
        logic               stamp_en;
        logic               claim_en;
        logic [FRAME_W-1:0] frame;
        logic [IDX_W-1:0]   claim_idx;
        logic [PID_W-1:0]   claim_pid;
        logic               drop_en;
        logic [PID_W-1:0]   drop_pid;
        logic               scan_start;
    } fr_ctrl_t;

    // frame scan outcome
    typedef struct packed {
        logic               done;
        logic               has_free;
        logic [FRAME_W-1:0] free_frame;
        logic [FRAME_W-1:0] victim;
        logic               owner_valid;
        logic [IDX_W-1:0]   owner_idx;
    } fr_scan_t;

endpackage

`default_nettype wire

@@ rtl/ptl_div.sv @@
// Split of a code line into page and offset by the constant page length,
// a reciprocal multiply with a registered result. Depends on ptl_pkg.
`default_nettype none

module ptl_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [ptl_pkg::LINE_W-1:0]    dividend,
    output logic                               done,
    output logic      [ptl_pkg::LINE_W-1:0]    quotient,
    output logic      [ptl_pkg::REM_W-1:0]     remainder
);
    import ptl_pkg::*;

    logic                  done_reg;
    logic [LINE_W-1:0]     quo_reg;
    logic [REM_W-1:0]      rem_reg;

    logic [DIV_PROD_W-1:0] prod;
    logic [LINE_W-1:0]     quo_calc;
    logic [LINE_W-1:0]     back;
    logic [REM_W-1:0]      rem_calc;

    always_comb
    begin
        prod     = DIV_PROD_W'(dividend) * DIV_PROD_W'(DIV_RECIP);
        quo_calc = prod[DIV_SHIFT +: LINE_W];
        back     = LINE_W'(int'(quo_calc) * LINES_PER_PAGE);
        rem_calc = REM_W'(dividend - back);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= quo_calc;
            rem_reg <= rem_calc;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

@@ rtl/ptl_page_table.sv @@
// Page table store: valid bits in flops, frame numbers in a registered-read memory.
// Depends on ptl_pkg.
`default_nettype none

module ptl_page_table (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire ptl_pkg::pt_ctrl_t             ctrl,
    output logic                               rd_valid,
    output logic      [ptl_pkg::FRAME_W-1:0]   rd_frame
);
    import ptl_pkg::*;

    logic                valid_reg [ENTRY_COUNT];
    logic                rd_valid_reg;
    logic [FRAME_W-1:0]  rd_frame_reg;
    logic [FRAME_W-1:0]  mem [ENTRY_COUNT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
            for (int e = 0; e < ENTRY_COUNT; e++)
            begin
                valid_reg[e] <= 1'b0;
            end
        end
        else
        begin
            if (ctrl.rd_en)
            begin
                rd_valid_reg <= valid_reg[ctrl.rd_idx];
            end
            // whole table of one process dropped at once
            for (int e = 0; e < ENTRY_COUNT; e++)
            begin
                if (ctrl.clr_en && ((e / PAGES_PER_TABLE) == int'(ctrl.clr_pid)))
                begin
                    valid_reg[e] <= 1'b0;
                end
            end
            if (ctrl.inv_en)
            begin
                valid_reg[ctrl.inv_idx] <= 1'b0;
            end
            if (ctrl.wr_en)
            begin
                valid_reg[ctrl.wr_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[ctrl.wr_idx] <= ctrl.wr_frame;
        end
        if (ctrl.rd_en)
        begin
            rd_frame_reg <= mem[ctrl.rd_idx];
        end
    end

    assign rd_valid = rd_valid_reg;
    assign rd_frame = rd_frame_reg;

endmodule

`default_nettype wire

@@ rtl/ptl_frames.sv @@
// Frame bookkeeping: free marks, LRU stamps, owner entries, and the frame scanner
// that walks one frame a cycle through a single stamp comparator. Depends on ptl_pkg.
`default_nettype none

module ptl_frames (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ptl_pkg::fr_ctrl_t ctrl,
    output ptl_pkg::fr_scan_t      scan
);
    import ptl_pkg::*;

    logic                  free_reg      [FRAME_COUNT];
    logic [STAMP_BITS-1:0] stamp_reg     [FRAME_COUNT];
    logic                  owner_vld_reg [FRAME_COUNT];
    logic [IDX_W-1:0]      owner_idx_reg [FRAME_COUNT];
    logic [PID_W-1:0]      owner_pid_reg [FRAME_COUNT];
    logic [STAMP_BITS-1:0] counter_reg;

    logic                  scan_busy_reg;
    logic                  scan_done_reg;
    logic [FRAME_W-1:0]    scan_idx_reg;
    logic                  has_free_reg;
    logic [FRAME_W-1:0]    free_frame_reg;
    logic [FRAME_W-1:0]    best_reg;
    logic [STAMP_BITS-1:0] best_stamp_reg;

    logic                  cur_free;
    logic [STAMP_BITS-1:0] cur_stamp;
    logic                  older;
    logic                  last;

    always_comb
    begin
        cur_free  = free_reg[scan_idx_reg];
        cur_stamp = stamp_reg[scan_idx_reg];
        // strict compare keeps the lowest index on ties
        older     = (scan_idx_reg == '0) || (cur_stamp < best_stamp_reg);
        last      = scan_idx_reg == FRAME_W'(FRAME_COUNT - 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg   <= '0;
            scan_busy_reg <= 1'b0;
            scan_done_reg <= 1'b0;
            scan_idx_reg  <= '0;
            has_free_reg  <= 1'b0;
            for (int f = 0; f < FRAME_COUNT; f++)
            begin
                free_reg[f]      <= 1'b1;
                stamp_reg[f]     <= '0;
                owner_vld_reg[f] <= 1'b0;
            end
        end
        else
        begin
            if (ctrl.stamp_en)
            begin
                stamp_reg[ctrl.frame] <= counter_reg;
                counter_reg           <= counter_reg + 1'b1;
            end
            for (int f = 0; f < FRAME_COUNT; f++)
            begin
                if (ctrl.drop_en && (owner_pid_reg[f] == ctrl.drop_pid))
                begin
                    owner_vld_reg[f] <= 1'b0;
                end
            end
            if (ctrl.claim_en)
            begin
                free_reg[ctrl.frame]      <= 1'b0;
                owner_vld_reg[ctrl.frame] <= 1'b1;
            end

            if (ctrl.scan_start)
            begin
                scan_busy_reg <= 1'b1;
                scan_done_reg <= 1'b0;
                scan_idx_reg  <= '0;
                has_free_reg  <= 1'b0;
            end
            else if (scan_busy_reg)
            begin
                if (cur_free && !has_free_reg)
                begin
                    has_free_reg <= 1'b1;
                end
                if (last)
                begin
                    scan_busy_reg <= 1'b0;
                    scan_done_reg <= 1'b1;
                end
                else
                begin
                    scan_idx_reg <= scan_idx_reg + 1'b1;
                end
            end
            else
            begin
                scan_done_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.claim_en)
        begin
            owner_idx_reg[ctrl.frame] <= ctrl.claim_idx;
            owner_pid_reg[ctrl.frame] <= ctrl.claim_pid;
        end
        if (scan_busy_reg && !ctrl.scan_start)
        begin
            if (older)
            begin
                best_reg       <= scan_idx_reg;
                best_stamp_reg <= cur_stamp;
            end
            if (cur_free && !has_free_reg)
            begin
                free_frame_reg <= scan_idx_reg;
            end
        end
    end

    always_comb
    begin
        scan.done        = scan_done_reg;
        scan.has_free    = has_free_reg;
        scan.free_frame  = free_frame_reg;
        scan.victim      = best_reg;
        scan.owner_valid = owner_vld_reg[best_reg];
        scan.owner_idx   = owner_idx_reg[best_reg];
    end

endmodule

`default_nettype wire

@@ rtl/paged_translation_lru_frames.sv @@
// A word is split into page and offset by ptl_div, then decoded. Create, free and
// rejected words finish there; an access or a fault reads the page table, and a
// fault that finds its page unmapped walks the frames and loads one. A new word is
// taken only after the last result is registered, which waits while an older one
// is not taken. Reset empties all tables, frees all frames and zeroes the stamps.
`default_nettype none

module paged_translation_lru_frames (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            item_valid,
    output logic                                 item_ready,
    input  wire logic [ptl_pkg::CMD_W-1:0]       cmd,
    input  wire logic [ptl_pkg::PID_W-1:0]       pid,
    input  wire logic [ptl_pkg::LINE_W-1:0]      code_line,
    output logic                                 result_valid,
    input  wire logic                            result_ready,
    output logic      [ptl_pkg::STATUS_W-1:0]    status,
    output logic      [ptl_pkg::FRAME_W-1:0]     frame,
    output logic      [ptl_pkg::ADDR_W-1:0]      mem_address,
    output logic                                 victim_valid,
    output logic      [ptl_pkg::FRAME_W-1:0]     victim_frame
);
    import ptl_pkg::*;

`include "paged_translation_lru_frames_defines.svh"

    state_t  state_reg, state_next;
    cmd_t    cmd_reg;
    logic [PID_W-1:0] pid_reg;
    logic    present_reg [NUM_PROCS];

    logic                res_load;
    status_t             res_status_reg, res_status_next;
    logic [FRAME_W-1:0]  res_frame_reg, res_frame_next;
    logic [ADDR_W-1:0]   res_addr_reg, res_addr_next;
    logic                res_vvalid_reg, res_vvalid_next;
    logic [FRAME_W-1:0]  res_vframe_reg, res_vframe_next;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [FRAME_W-1:0]  out_frame_reg;
    logic [ADDR_W-1:0]   out_addr_reg;
    logic                out_vvalid_reg;
    logic [FRAME_W-1:0]  out_vframe_reg;

    logic                accept;
    logic                out_load;
    logic                present_set;
    logic                present_clr;

    logic [LINE_W-1:0]   div_quo;
    logic [REM_W-1:0]    div_rem;
    logic                div_done;

    logic                pid_ok;
    logic                has_table;
    logic                page_ok;
    logic [IDX_W-1:0]    idx;
    logic [FRAME_W-1:0]  pick;

    pt_ctrl_t            pt_ctrl;
    logic                pt_rd_valid;
    logic [FRAME_W-1:0]  pt_rd_frame;
    fr_ctrl_t            fr_ctrl;
    fr_scan_t            fr_scan;

    function automatic logic [ADDR_W-1:0] line_addr(logic [FRAME_W-1:0] f,
                                                    logic [REM_W-1:0] off);
        line_addr = ADDR_W'(int'(f) * LINES_PER_PAGE + int'(off));
    endfunction

    ptl_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (accept),
        .dividend  (code_line),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    ptl_page_table u_page_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (pt_ctrl),
        .rd_valid (pt_rd_valid),
        .rd_frame (pt_rd_frame)
    );

    ptl_frames u_frames (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (fr_ctrl),
        .scan  (fr_scan)
    );

    always_comb
    begin
        item_ready = state_reg == S_IDLE;
        accept     = item_valid && item_ready;
        pid_ok     = int'(pid_reg) < NUM_PROCS;
        has_table  = pid_ok && present_reg[pid_reg];
        page_ok    = int'(div_quo) < PAGES_PER_TABLE;
        idx        = IDX_W'(int'(pid_reg) * PAGES_PER_TABLE + int'(div_quo));
        pick       = fr_scan.has_free ? fr_scan.free_frame : fr_scan.victim;
    end

    always_comb
    begin
        state_next      = state_reg;
        res_load        = 1'b0;
        res_status_next = ST_OK;
        res_frame_next  = '0;
        res_addr_next   = '0;
        res_vvalid_next = 1'b0;
        res_vframe_next = '0;
        present_set     = 1'b0;
        present_clr     = 1'b0;
        out_load        = 1'b0;
        pt_ctrl         = '0;
        fr_ctrl         = '0;
        pt_ctrl.rd_idx  = idx;
        pt_ctrl.wr_idx  = idx;
        pt_ctrl.clr_pid = pid_reg;
        fr_ctrl.claim_idx = idx;
        fr_ctrl.claim_pid = pid_reg;
        fr_ctrl.drop_pid  = pid_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_FINISH;
                res_load   = 1'b1;
                if (cmd_reg == CMD_CREATE)
                begin
                    if (!pid_ok)
                    begin
                        res_status_next = ST_NO_TABLE;
                    end
                    else if (present_reg[pid_reg])
                    begin
                        res_status_next = ST_EXISTS;
                    end
                    else
                    begin
                        present_set     = 1'b1;
                        pt_ctrl.clr_en  = 1'b1;
                        fr_ctrl.drop_en = 1'b1;
                    end
                end
                else if (!has_table)
                begin
                    res_status_next = ST_NO_TABLE;
                end
                else if (cmd_reg == CMD_FREE)
                begin
                    // frames stay occupied; only their back-pointers go
                    present_clr     = 1'b1;
                    pt_ctrl.clr_en  = 1'b1;
                    fr_ctrl.drop_en = 1'b1;
                end
                else if (!page_ok)
                begin
                    res_status_next = ST_RANGE;
                end
                else
                begin
                    res_load      = 1'b0;
                    pt_ctrl.rd_en = 1'b1;
                    state_next    = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                if (pt_rd_valid)
                begin
                    res_load        = 1'b1;
                    res_frame_next  = pt_rd_frame;
                    res_addr_next   = line_addr(pt_rd_frame, div_rem);
                    fr_ctrl.frame   = pt_rd_frame;
                    fr_ctrl.stamp_en = (cmd_reg == CMD_ACCESS) &&
                                       (int'(pt_rd_frame) < FRAME_COUNT);
                    state_next      = S_FINISH;
                end
                else if (cmd_reg == CMD_ACCESS)
                begin
                    res_load        = 1'b1;
                    res_status_next = ST_FAULT;
                    state_next      = S_FINISH;
                end
                else
                begin
                    fr_ctrl.scan_start = 1'b1;
                    state_next         = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (fr_scan.done)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                res_load         = 1'b1;
                res_frame_next   = pick;
                res_addr_next    = line_addr(pick, div_rem);
                fr_ctrl.frame    = pick;
                fr_ctrl.stamp_en = 1'b1;
                fr_ctrl.claim_en = 1'b1;
                pt_ctrl.wr_en    = 1'b1;
                pt_ctrl.wr_frame = pick;
                if (fr_scan.has_free)
                begin
                    res_status_next = ST_LOADED;
                end
                else
                begin
                    res_status_next = ST_EVICTED;
                    res_vvalid_next = 1'b1;
                    res_vframe_next = pick;
                    // at most one entry maps a frame; kill it if still live
                    pt_ctrl.inv_en  = fr_scan.owner_valid;
                    pt_ctrl.inv_idx = fr_scan.owner_idx;
                end
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            for (int p = 0; p < NUM_PROCS; p++)
            begin
                present_reg[p] <= 1'b0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (present_set)
            begin
                present_reg[pid_reg] <= 1'b1;
            end
            if (present_clr)
            begin
                present_reg[pid_reg] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_t'(cmd);
            pid_reg <= pid;
        end
        if (res_load)
        begin
            res_status_reg <= res_status_next;
            res_frame_reg  <= res_frame_next;
            res_addr_reg   <= res_addr_next;
            res_vvalid_reg <= res_vvalid_next;
            res_vframe_reg <= res_vframe_next;
        end
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_frame_reg  <= res_frame_reg;
            out_addr_reg   <= res_addr_reg;
            out_vvalid_reg <= res_vvalid_reg;
            out_vframe_reg <= res_vframe_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign status       = out_status_reg;
    assign frame        = out_frame_reg;
    assign mem_address  = out_addr_reg;
    assign victim_valid = out_vvalid_reg;
    assign victim_frame = out_vframe_reg;

    `PTL_ASSERT_NEXT(a_busy_after_accept, accept, !item_ready,
        "ready still high after a word was taken")
    `PTL_ASSERT_NOW(a_victim_only_on_evict, result_valid && victim_valid,
        status == ST_EVICTED, "victim reported without eviction status")
    `PTL_ASSERT_NOW(a_no_frame_on_reject,
        result_valid && (status == ST_FAULT || status == ST_NO_TABLE ||
        status == ST_RANGE || status == ST_EXISTS),
        frame == '0 && mem_address == '0, "frame given for a rejected word")
    `PTL_ASSERT_NOW(a_scan_done_in_scan, fr_scan.done, state_reg == S_SCAN,
        "frame scan finished outside the scan state")

endmodule

`default_nettype wire
